@@ design/civ_pkg.sv @@
// Shared types, constants and reply tables for the CI-V frame responder.
`timescale 1ns / 1ps

package civ_pkg;

    // Frame geometry
    localparam int FRAME_LEN   = 11;
    localparam int REPLY_LEN   = 17;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(REPLY_LEN);

    // Protocol bytes
    localparam logic [7:0] PREAMBLE      = 8'hFE;
    localparam logic [7:0] END_OF_MSG    = 8'hFD;
    localparam logic [7:0] CMD_READ_FREQ = 8'h03;
    localparam logic [7:0] CMD_SET_FREQ  = 8'h05;
    localparam logic [7:0] CMD_SET_MODE  = 8'h06;

    // Address register reset values
    localparam logic [7:0] RADIO_ADDR_RST = 8'h70;
    localparam logic [7:0] CTRL_ADDR_RST  = 8'hE0;

    // Frame lengths being gathered
    localparam logic [3:0] SHORT_TARGET = 4'd6;
    localparam logic [3:0] MODE_TARGET  = 4'd10;
    localparam logic [3:0] SET_TARGET   = 4'd11;

    // Configuration register indexes
    localparam logic REG_RADIO_ADDR = 1'b0;
    localparam logic REG_CTRL_ADDR  = 1'b1;

    typedef enum logic {
        JOB_FREQ_QUERY,
        JOB_FREQ_SET
    } job_kind_t;

    // One pending reply: echoed frame plus the frequency to report
    typedef struct packed {
        job_kind_t                  kind;
        logic [FRAME_LEN-1:0][7:0]  frame;
        logic [31:0]                freq;
    } reply_job_t;

    // Fixed frequency reply, 11 bytes
    function automatic logic [7:0] freq_reply_byte(input logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'hFE;
            4'd1:    b = 8'hFE;
            4'd2:    b = 8'hE0;
            4'd3:    b = 8'h70;
            4'd4:    b = 8'h03;
            4'd5:    b = 8'h04;
            4'd6:    b = 8'h32;
            4'd7:    b = 8'h21;
            4'd8:    b = 8'h14;
            4'd9:    b = 8'h00;
            4'd10:   b = 8'hFD;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Fixed OK reply, 6 bytes
    function automatic logic [7:0] ok_reply_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'hFE;
            3'd1:    b = 8'hFE;
            3'd2:    b = 8'hE0;
            3'd3:    b = 8'h70;
            3'd4:    b = 8'hFB;
            3'd5:    b = 8'hFD;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Weight of a BCD byte (two digits) at position k: 100^k
    function automatic logic [31:0] pow100(input logic [2:0] k);
        logic [31:0] w;
        case (k)
            3'd0:    w = 32'd1;
            3'd1:    w = 32'd100;
            3'd2:    w = 32'd10000;
            3'd3:    w = 32'd1000000;
            3'd4:    w = 32'd100000000;
            default: w = 32'd0;
        endcase
        return w;
    endfunction

endpackage

@@ design/civ_frame_parser.sv @@
// Front end: gathers received bytes into frames, checks headers, decodes frequency.
`timescale 1ns / 1ps

module civ_frame_parser (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,      // [7:0] rx_byte
    input  logic               cfg_wr_en,
    input  logic               cfg_addr,
    input  logic [7:0]         cfg_wr_data,
    input  logic               q_full,
    output logic               push,
    output civ_pkg::reply_job_t push_job
);
    import civ_pkg::*;

    logic [7:0]               radio_addr_reg;
    logic [7:0]               ctrl_addr_reg;
    logic [FRAME_LEN-1:0][7:0] store_reg;
    logic [3:0]               count_reg, count_next;
    logic [3:0]               target_reg, target_next;
    logic [31:0]              acc_reg, acc_next;
    logic [31:0]              freq_reg, freq_next;

    logic                     accept;
    logic [3:0]               cnt_eff, tgt_eff, cnt_inc;
    logic [FRAME_LEN-1:0][7:0] frame_view;
    logic                     header_ok;
    logic [7:0]               digit_pair;
    logic [2:0]               weight_idx;
    logic [31:0]              term;
    logic [31:0]              set_freq;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && !q_full;

    // Recover from an out-of-range count or target by starting a fresh frame
    always_comb begin
        if (count_reg >= 4'(FRAME_LEN) || target_reg > 4'(FRAME_LEN)) begin
            cnt_eff = '0;
            tgt_eff = SHORT_TARGET;
        end else begin
            cnt_eff = count_reg;
            tgt_eff = target_reg;
        end
        cnt_inc = cnt_eff + 4'd1;
    end

    // Frame as it stands with the incoming byte in place
    always_comb begin
        for (int i = 0; i < FRAME_LEN; i++) begin
            frame_view[i] = (cnt_eff == 4'(i)) ? s_tdata : store_reg[i];
        end
    end

    assign header_ok = (frame_view[0] == PREAMBLE) && (frame_view[1] == PREAMBLE) &&
                       (frame_view[2] == radio_addr_reg) && (frame_view[3] == ctrl_addr_reg);

    // Running BCD sum over bytes 5..9: lo + 10*hi, weighted by 100^k
    assign digit_pair = {4'b0, s_tdata[3:0]} + {1'b0, s_tdata[7:4], 3'b0}
                      + {3'b0, s_tdata[7:4], 1'b0};
    assign weight_idx = 3'(cnt_eff - 4'd5);
    assign term       = 32'(digit_pair * pow100(weight_idx));
    assign set_freq   = (s_tdata == END_OF_MSG) ? acc_reg : 32'd0;

    always_comb begin
        acc_next = acc_reg;
        if (accept && cnt_eff == 4'd5) begin
            acc_next = term;
        end else if (accept && cnt_eff > 4'd5 && cnt_eff < 4'd10) begin
            acc_next = acc_reg + term;
        end
    end

    // Frame completion and classification
    always_comb begin
        count_next     = count_reg;
        target_next    = target_reg;
        freq_next      = freq_reg;
        push           = 1'b0;
        push_job.kind  = JOB_FREQ_QUERY;
        push_job.frame = frame_view;
        push_job.freq  = freq_reg;
        if (accept) begin
            count_next  = cnt_inc;
            target_next = tgt_eff;
            if (cnt_inc >= tgt_eff) begin
                count_next  = '0;
                target_next = SHORT_TARGET;
                if (tgt_eff == SHORT_TARGET) begin
                    if (header_ok) begin
                        if (frame_view[4] == CMD_READ_FREQ) begin
                            push = (frame_view[5] == END_OF_MSG);
                        end else if (frame_view[4] == CMD_SET_FREQ) begin
                            count_next  = cnt_inc;
                            target_next = SET_TARGET;
                        end else if (frame_view[4] == CMD_SET_MODE) begin
                            count_next  = cnt_inc;
                            target_next = MODE_TARGET;
                        end
                    end
                end else if (tgt_eff == SET_TARGET) begin
                    freq_next     = set_freq;
                    push          = 1'b1;
                    push_job.kind = JOB_FREQ_SET;
                    push_job.freq = set_freq;
                end
            end
        end
    end

    // Control state and address registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            target_reg     <= SHORT_TARGET;
            freq_reg       <= '0;
            radio_addr_reg <= RADIO_ADDR_RST;
            ctrl_addr_reg  <= CTRL_ADDR_RST;
        end else begin
            count_reg  <= count_next;
            target_reg <= target_next;
            freq_reg   <= freq_next;
            if (cfg_wr_en && cfg_addr == REG_RADIO_ADDR) begin
                radio_addr_reg <= cfg_wr_data;
            end
            if (cfg_wr_en && cfg_addr == REG_CTRL_ADDR) begin
                ctrl_addr_reg <= cfg_wr_data;
            end
        end
    end

    // Frame bytes and partial sum
    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        for (int i = 0; i < FRAME_LEN; i++) begin
            if (accept && cnt_eff == 4'(i)) begin
                store_reg[i] <= s_tdata;
            end
        end
    end

    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg < 4'(FRAME_LEN))
        else $error("byte count left frame range");
    a_target_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        target_reg == SHORT_TARGET || target_reg == MODE_TARGET || target_reg == SET_TARGET)
        else $error("illegal frame target");
    a_push_on_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> accept && count_next == 4'd0)
        else $error("reply pushed outside a frame end");

endmodule

@@ design/civ_cmd_fifo.sv @@
// Two-entry queue of pending replies between the parser and the emitter.
`timescale 1ns / 1ps

module civ_cmd_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  civ_pkg::reply_job_t push_job,
    output logic                full,
    input  logic                pop,
    output logic                head_valid,
    output civ_pkg::reply_job_t head_job
);
    import civ_pkg::*;

    reply_job_t          mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0]   fill_reg;

    assign full       = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (fill_reg != '0);
    assign head_job   = mem_reg[rd_ptr_reg];

    // Pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                fill_reg <= fill_reg + 1'b1;
            end else if (pop && !push) begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    // Entry storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && full))
        else $error("push into full reply queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("pop from empty reply queue");

endmodule

@@ design/civ_reply_emitter.sv @@
// Back end: walks a queued reply byte by byte into the output register.
`timescale 1ns / 1ps

module civ_reply_emitter (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                head_valid,
    input  civ_pkg::reply_job_t head_job,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [39:0]         m_tdata,   // [7:0] tx_byte, [39:8] current_frequency
    output logic                m_tlast    // last_byte
);
    import civ_pkg::*;

    logic [IDX_W-1:0] idx_reg;
    logic             m_tvalid_reg;
    logic [39:0]      m_tdata_reg;
    logic             m_tlast_reg;

    logic             load;
    logic             is_last;
    logic [7:0]       echo_byte;
    logic [7:0]       tx_byte;

    assign load    = head_valid && (!m_tvalid_reg || m_tready);
    assign is_last = (idx_reg == IDX_W'(REPLY_LEN - 1));
    assign pop     = load && is_last;

    // Byte selection: echo first, then the fixed reply
    always_comb begin
        echo_byte = (idx_reg < IDX_W'(FRAME_LEN)) ? head_job.frame[idx_reg[3:0]] : 8'h00;
        unique case (head_job.kind)
            JOB_FREQ_QUERY: begin
                if (idx_reg < IDX_W'(REPLY_LEN - FRAME_LEN)) begin
                    tx_byte = echo_byte;
                end else begin
                    tx_byte = freq_reply_byte(4'(idx_reg - IDX_W'(REPLY_LEN - FRAME_LEN)));
                end
            end
            JOB_FREQ_SET: begin
                if (idx_reg < IDX_W'(FRAME_LEN)) begin
                    tx_byte = echo_byte;
                end else begin
                    tx_byte = ok_reply_byte(3'(idx_reg - IDX_W'(FRAME_LEN)));
                end
            end
            default: tx_byte = 8'h00;
        endcase
    end

    // Output register and byte index
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_tvalid_reg <= 1'b1;
                idx_reg      <= is_last ? '0 : idx_reg + 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            m_tdata_reg <= {head_job.freq, tx_byte};
            m_tlast_reg <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    a_idx_range: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg < IDX_W'(REPLY_LEN))
        else $error("reply index out of range");
    a_pop_marks_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> m_tvalid && m_tlast)
        else $error("reply popped without last byte shown");
    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> idx_reg == '0)
        else $error("last byte shown mid-reply");

endmodule

@@ design/civ_cat_frame_responder_unit.sv @@
// Top level of the CI-V frame responder: parser, reply queue and emitter.
`timescale 1ns / 1ps

// Received bytes enter on s_* at up to one transfer per cycle; frames of 6, 10
// or 11 bytes are checked against the two address registers, and a valid
// frequency query or frequency set queues a 17-byte reply (echo plus fixed
// answer). Replies leave on m_* at one byte per cycle while m_tready is high,
// from a registered output stage, each carrying the stored frequency and tlast
// on its final byte. The edge that takes a frame's last byte writes the reply
// queue; the output register is then loaded from the queue head once it is
// free, and a reply holds the output until its last byte is taken.
// The reply queue holds two pending replies; s_tready drops only while it is
// full, so sustained input is limited by the emission of each reply.
// The address registers are written through cfg_wr_en / cfg_addr / cfg_wr_data,
// index 0 the radio address and index 1 the controller address. No clearing
// pass is needed after reset.
module civ_cat_frame_responder_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,      // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,      // [7:0] tx_byte, [39:8] current_frequency
    output logic        m_tlast,      // last_byte
    input  logic        cfg_wr_en,
    input  logic        cfg_addr,
    input  logic [7:0]  cfg_wr_data
);
    import civ_pkg::*;

    logic       push;
    reply_job_t push_job;
    logic       q_full;
    logic       pop;
    logic       head_valid;
    reply_job_t head_job;

    civ_frame_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .q_full      (q_full),
        .push        (push),
        .push_job    (push_job)
    );

    civ_cmd_fifo u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_job   (push_job),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    civ_reply_emitter u_emitter (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule
